FILE: hdl/brpu_pkg.sv
// Shared types and constants for the BMP 24-bit pixel unpacker.
`default_nettype none
package brpu_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_ORDER   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd4;

  localparam logic [1:0] MODE_BGR     = 2'd0;
  localparam logic [1:0] MODE_RGB     = 2'd1;
  localparam logic [1:0] MODE_BGR_KEY = 2'd2;

  localparam logic [23:0] KEY_COLOR = 24'h000001;

  typedef struct packed {
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  byte_order_mode;
    logic [11:0] origin_x;
    logic [11:0] origin_y;
  } brpu_cfg_t;

  typedef struct packed {
    logic [12:0] screen_x;
    logic [12:0] screen_y;
    logic [23:0] pixel_color;
    logic        frame_last;
  } brpu_pix_t;

endpackage
`default_nettype wire

FILE: hdl/brpu_cfg_regs.sv
// Configuration register file for the BMP 24-bit pixel unpacker.
`default_nettype none
module brpu_cfg_regs
  import brpu_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output brpu_cfg_t                   cfg
);

  brpu_cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.image_width     <= 13'd1;
      regs.image_height    <= 13'd1;
      regs.byte_order_mode <= MODE_BGR;
      regs.origin_x        <= 12'd0;
      regs.origin_y        <= 12'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  regs.image_width     <= cfg_data;
        REG_IMAGE_HEIGHT: regs.image_height    <= cfg_data;
        REG_BYTE_ORDER:   regs.byte_order_mode <= cfg_data[1:0];
        REG_ORIGIN_X:     regs.origin_x        <= cfg_data[11:0];
        REG_ORIGIN_Y:     regs.origin_y        <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/brpu_decode.sv
// Byte-phase, padding and position tracking with pixel assembly.
`default_nettype none
module brpu_decode
  import brpu_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] data_byte,
  input  wire logic       frame_start,
  input  wire brpu_cfg_t  cfg,
  output logic            emit,
  output brpu_pix_t       pix
);

  localparam int unsigned CntW = $clog2(MAX_DIM);
  localparam int unsigned DimW = CntW + 1;
  localparam int unsigned SumW = (DimW > 13) ? DimW : 13;

  logic [CntW-1:0] column_count, column_count_next;
  logic [CntW-1:0] row_count, row_count_next;
  logic [1:0]      byte_phase, byte_phase_next;
  logic [1:0]      pad_remaining, pad_remaining_next;
  logic [15:0]     held_bytes, held_bytes_next;

  logic [DimW-1:0] w, h;
  logic [CntW-1:0] col_cur, row_cur;
  logic [1:0]      phase_cur, pad_cur;
  logic [15:0]     held_cur;
  logic [DimW-1:0] col_inc, row_inc, flipped;
  logic            row_end, img_end;
  logic [23:0]     color;
  logic [SumW-1:0] sum_x, sum_y;

  always_comb begin
    if (cfg.image_width == 13'd0) begin
      w = DimW'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_DIM)) begin
      w = DimW'(MAX_DIM);
    end else begin
      w = DimW'(cfg.image_width);
    end
    if (cfg.image_height == 13'd0) begin
      h = DimW'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_DIM)) begin
      h = DimW'(MAX_DIM);
    end else begin
      h = DimW'(cfg.image_height);
    end
  end

  always_comb begin
    col_cur   = frame_start ? '0 : column_count;
    row_cur   = frame_start ? '0 : row_count;
    phase_cur = frame_start ? 2'd0 : byte_phase;
    pad_cur   = frame_start ? 2'd0 : pad_remaining;
    held_cur  = frame_start ? 16'd0 : held_bytes;

    col_inc = DimW'(col_cur) + DimW'(1);
    row_inc = DimW'(row_cur) + DimW'(1);
    row_end = col_inc >= w;
    img_end = row_end && (row_inc >= h);
    flipped = (DimW'(row_cur) < h) ? (h - row_inc) : '0;

    if (cfg.byte_order_mode == MODE_RGB) begin
      color = {held_cur[15:8], held_cur[7:0], data_byte};
    end else begin
      color = {data_byte, held_cur[7:0], held_cur[15:8]};
    end

    sum_x = SumW'(cfg.origin_x) + SumW'(col_cur);
    sum_y = SumW'(cfg.origin_y) + SumW'(flipped);

    pix.screen_x    = sum_x[12:0];
    pix.screen_y    = sum_y[12:0];
    pix.pixel_color = color;
    pix.frame_last  = img_end;

    column_count_next  = col_cur;
    row_count_next     = row_cur;
    byte_phase_next    = phase_cur;
    pad_remaining_next = pad_cur;
    held_bytes_next    = held_cur;
    emit               = 1'b0;

    if (pad_cur != 2'd0) begin
      pad_remaining_next = pad_cur - 2'd1;
    end else begin
      case (phase_cur)
        2'd0: begin
          held_bytes_next = {data_byte, 8'd0};
          byte_phase_next = 2'd1;
        end
        2'd1: begin
          held_bytes_next = {held_cur[15:8], data_byte};
          byte_phase_next = 2'd2;
        end
        default: begin
          byte_phase_next = 2'd0;
          emit = !((cfg.byte_order_mode == MODE_BGR_KEY) && (color == KEY_COLOR));
          if (row_end) begin
            column_count_next  = '0;
            pad_remaining_next = w[1:0];
            row_count_next     = img_end ? '0 : row_inc[CntW-1:0];
          end else begin
            column_count_next = col_inc[CntW-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      row_count     <= '0;
      byte_phase    <= 2'd0;
      pad_remaining <= 2'd0;
      held_bytes    <= 16'd0;
    end else if (fire) begin
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      byte_phase    <= byte_phase_next;
      pad_remaining <= pad_remaining_next;
      held_bytes    <= held_bytes_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/bmp_rgb24_pixel_unpacker_unit.sv
// Top level of the BMP 24-bit pixel unpacker: input register, decoder, result register.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     data_byte, frame_start
//   out      out_valid / out_ready   screen_x, screen_y, pixel_color, frame_last
//   cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte request is taken per cycle unless the result stalls; its third byte builds a pixel.
// The rate is set by the single decode step between the input and result registers.
// Reset is synchronous and clears the counters, phase, padding and valid flags.
// A stalled result holds the decoder, and the input register then fills and drops in_ready.
`default_nettype none
module bmp_rgb24_pixel_unpacker_unit
  import brpu_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   frame_start,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [12:0]                 screen_x,
  output logic [12:0]                 screen_y,
  output logic [23:0]                 pixel_color,
  output logic                        frame_last,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  brpu_cfg_t cfg;
  brpu_pix_t pix;
  brpu_pix_t res;
  logic      in_full;
  logic [7:0] in_byte;
  logic      in_start;
  logic      out_free, fire, emit;

  brpu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free = !out_valid || out_ready;
  assign fire     = in_full && out_free;
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte  <= data_byte;
      in_start <= frame_start;
    end
  end

  brpu_decode #(
    .MAX_DIM (MAX_DIM)
  ) u_decode (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (in_byte),
    .frame_start (in_start),
    .cfg         (cfg),
    .emit        (emit),
    .pix         (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res <= pix;
    end
  end

  assign screen_x    = res.screen_x;
  assign screen_y    = res.screen_y;
  assign pixel_color = res.pixel_color;
  assign frame_last  = res.frame_last;

endmodule
`default_nettype wire

FILE: test/tb_bmp_rgb24_pixel_unpacker_unit.sv
// Testbench for the BMP 24-bit pixel unpacker with directed and random byte streams.
module tb_bmp_rgb24_pixel_unpacker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import brpu_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [1:0] MODE_BGR_ALT = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 45;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [12:0] screen_x;
  logic [12:0] screen_y;
  logic [23:0] pixel_color;
  logic frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the register file and of the decoder position.
  logic [12:0] cfg_width = 13'd1;
  logic [12:0] cfg_height = 13'd1;
  logic [1:0] cfg_mode = MODE_BGR;
  logic [11:0] cfg_origin_x = '0;
  logic [11:0] cfg_origin_y = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [1:0] byte_slot = '0;
  logic [1:0] pad_left = '0;
  logic [15:0] held_pair = '0;

  brpu_pix_t expected_pixels[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned run_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  bit hold_request = 1'b0;

  bmp_rgb24_pixel_unpacker_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .screen_x(screen_x),
    .screen_y(screen_y),
    .pixel_color(pixel_color),
    .frame_last(frame_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned dim_clamp(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return v;
  endfunction

  task automatic predict_byte(input logic [7:0] value, input logic mark);
    int unsigned w;
    int unsigned h;
    int unsigned flipped;
    logic [23:0] color;
    logic row_end;
    logic img_end;
    brpu_pix_t px;
    w = dim_clamp(cfg_width);
    h = dim_clamp(cfg_height);
    if (mark) begin
      col_pos = 0;
      row_pos = 0;
      byte_slot = 2'd0;
      pad_left = 2'd0;
      held_pair = '0;
    end
    if (pad_left != 0) begin
      pad_left--;
      return;
    end
    if (byte_slot == 2'd0) begin
      held_pair = {value, 8'h00};
      byte_slot = 2'd1;
      return;
    end
    if (byte_slot == 2'd1) begin
      held_pair[7:0] = value;
      byte_slot = 2'd2;
      return;
    end
    byte_slot = 2'd0;
    if (cfg_mode == MODE_RGB) color = {held_pair[15:8], held_pair[7:0], value};
    else color = {value, held_pair[7:0], held_pair[15:8]};
    flipped = (row_pos < h) ? h - 1 - row_pos : 0;
    row_end = (col_pos + 1) >= w;
    img_end = row_end && ((row_pos + 1) >= h);
    if (!(cfg_mode == MODE_BGR_KEY && color == KEY_COLOR)) begin
      px.screen_x = 13'(cfg_origin_x + col_pos);
      px.screen_y = 13'(cfg_origin_y + flipped);
      px.pixel_color = color;
      px.frame_last = img_end;
      expected_pixels.push_back(px);
    end
    if (row_end) begin
      col_pos = 0;
      pad_left = 2'(w & 3);
      if (img_end) row_pos = 0;
      else row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  task automatic check_pixel();
    brpu_pix_t want;
    if (expected_pixels.size() == 0) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display("Unexpected pixel: x=%0d y=%0d color=%06h last=%0b",
                 screen_x, screen_y, pixel_color, frame_last);
      return;
    end
    want = expected_pixels.pop_front();
    if (screen_x !== want.screen_x || screen_y !== want.screen_y ||
        pixel_color !== want.pixel_color || frame_last !== want.frame_last) begin
      fault_count++;
      if (fault_count <= MAX_REPORTS)
        $display({"Pixel mismatch: expected x=%0d y=%0d color=%06h last=%0b,",
                  " got x=%0d y=%0d color=%06h last=%0b"},
                 want.screen_x, want.screen_y, want.pixel_color, want.frame_last,
                 screen_x, screen_y, pixel_color, frame_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_pixel();
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (receiver_calm) begin
      out_ready <= 1'b1;
    end else if (run_left != 0) begin
      run_left--;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      run_left = $urandom_range(1, 16);
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic mark);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if (!sender_calm) begin
        gap = $urandom_range(1, 5);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    data_byte <= value;
    frame_start <= mark;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(value, mark);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH: cfg_width = value;
      REG_IMAGE_HEIGHT: cfg_height = value;
      REG_BYTE_ORDER: cfg_mode = value[1:0];
      REG_ORIGIN_X: cfg_origin_x = value[11:0];
      REG_ORIGIN_Y: cfg_origin_y = value[11:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [12:0] w, input logic [12:0] h, input logic [12:0] mode,
                            input logic [12:0] ox, input logic [12:0] oy);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_BYTE_ORDER, mode);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned budget);
    int unsigned w;
    int unsigned h;
    int unsigned base;
    logic [23:0] trio;
    logic mark;
    w = dim_clamp(cfg_width);
    h = dim_clamp(cfg_height);
    base = bytes_sent;
    mark = ($urandom_range(0, 7) != 0);
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if (bytes_sent - base >= budget) return;
        case ($urandom_range(0, 9))
          0: trio = 24'h010000;
          1: trio = 24'h000001;
          2: trio = 24'hFFFFFF;
          3: trio = 24'h000000;
          default: trio = 24'($urandom);
        endcase
        send_byte(trio[23:16], mark);
        mark = 1'b0;
        send_byte(trio[15:8], 1'b0);
        send_byte(trio[7:0], 1'b0);
      end
      repeat (w & 3) send_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic test_reset_values();
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
  endtask

  task automatic test_transparent_key();
    wait_idle();
    set_config(13'd0, 13'd1, 13'(MODE_BGR_KEY), 13'd0, 13'd0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
  endtask

  task automatic test_large_frame_restart();
    wait_idle();
    set_config(13'h1FFF, 13'h1FFF, 13'(MODE_BGR_ALT), 13'h1FFF, 13'h1FFF);
    send_byte(8'h01, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'h11, 1'b1);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
  endtask

  task automatic test_row_beyond_height();
    wait_idle();
    set_config(13'd1, 13'd4, 13'(MODE_RGB), 13'd100, 13'd200);
    send_byte(8'hC0, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h5A, 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    write_reg(REG_SPARE, 13'h0155);
    cfg_valid <= 1'b0;
    send_byte(8'h3C, 1'b0);
    send_byte(8'hE7, 1'b0);
    send_byte(8'h18, 1'b0);
  endtask

  task automatic test_receiver_hold();
    wait_idle();
    set_config(13'd5, 13'd3, 13'(MODE_RGB), 13'd10, 13'd20);
    sender_calm = 1'b1;
    receiver_calm = 1'b1;
    hold_request = 1'b1;
    send_frame(200);
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  task automatic test_sender_pause();
    wait_idle();
    set_config(13'd3, 13'd2, 13'(MODE_BGR), 13'd0, 13'd0);
    send_frame(12);
    wait_idle();
    send_frame(60);
  endtask

  task automatic test_random_frames();
    int unsigned base;
    logic [12:0] w;
    logic [12:0] h;
    repeat (RANDOM_PHASES) begin
      wait_idle();
      case ($urandom_range(0, 19))
        0: w = 13'd0;
        1, 2, 3: w = 13'($urandom);
        default: w = 13'($urandom_range(1, 9));
      endcase
      case ($urandom_range(0, 9))
        0: h = 13'($urandom);
        default: h = 13'($urandom_range(1, 4));
      endcase
      set_config(w, h, 13'($urandom_range(0, 3)), 13'($urandom), 13'($urandom));
      sender_calm = ($urandom_range(0, 3) == 0);
      receiver_calm = ($urandom_range(0, 3) == 0);
      base = bytes_sent;
      while (bytes_sent - base < PHASE_ITEMS) begin
        if ($urandom_range(0, 19) == 0)
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), ($urandom_range(0, 1) == 1));
        else
          send_frame(PHASE_ITEMS - (bytes_sent - base));
      end
    end
    sender_calm = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_transparent_key();
    test_large_frame_restart();
    test_row_beyond_height();
    test_receiver_hold();
    test_sender_pause();
    test_random_frames();
    wait_idle();
    if (fault_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
